FILE: rtl/core/fswb_pkg.sv
package fswb_pkg;

   localparam int SECTOR_BYTES = 512;
   localparam int SECTOR_COUNT = 8;
   localparam int STORE_BYTES  = SECTOR_BYTES * SECTOR_COUNT;

   localparam int OFF_W   = $clog2(SECTOR_BYTES);
   localparam int SEC_W   = $clog2(SECTOR_COUNT);
   localparam int ADDR_W  = $clog2(STORE_BYTES);
   localparam int SWEEP_W = OFF_W + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [7:0] ERASED_BYTE = 8'hFF;

   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_FLUSH = 2'd2;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   typedef struct packed {
      logic [1:0]       op;
      logic [SEC_W-1:0] sec;
      logic [OFF_W-1:0] off;
      logic [7:0]       wdata;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: rtl/core/flash_sector_writeback_buffer.sv
// Byte store emulating EEPROM on flash through one write-back sector buffer.
// Command channel: drive req_mode (read, write, flush), req_addr and req_wdata
// with start; the beat is taken on a clock edge where start is high and busy
// is low. The address wraps modulo the 4096-byte store.
// Result channel: one beat per command, rsp_rdata valid for the single cycle
// rsp_valid is high; the receiver cannot stall, so results never wait.
// A flush writes the buffered sector back in a 512-byte sweep; a write to
// another sector runs that write-back sweep and then a 512-byte load sweep
// before its byte is put, one byte a cycle through the buffer and flash
// memories. Reads and writes to the buffered sector need no sweep.
// Throughput is set by the back end: one buffer write per cycle between sweeps;
// a read goes through S_READ first. A two-entry command queue lets the front keep
// accepting beats while a sweep runs; busy rises once queue and front stage fill.
// Reset: synchronous; afterwards a clearing pass erases the 512-byte buffer
// to 0xFF with busy held high. Flash sectors read as erased 0xFF until first
// written back.
module flash_sector_writeback_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_addr,
   input  logic [7:0]  req_wdata,
   output logic        rsp_valid,
   output logic [7:0]  rsp_rdata
);

   fswb_pkg::queue_status_type q_status;
   fswb_pkg::cmd_type          push_cmd;
   fswb_pkg::cmd_type          head;
   logic                       push;
   logic                       pop;
   logic                       init_busy;

   fswb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .hold      (init_busy),
      .req_mode  (req_mode),
      .req_addr  (req_addr),
      .req_wdata (req_wdata),
      .q_status  (q_status),
      .busy      (busy),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   fswb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   fswb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .init_busy (init_busy),
      .rsp_valid (rsp_valid),
      .rsp_rdata (rsp_rdata)
   );

endmodule

FILE: rtl/core/fswb_front.sv
module fswb_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      hold,
   input  logic [1:0]                req_mode,
   input  logic [15:0]               req_addr,
   input  logic [7:0]                req_wdata,
   input  fswb_pkg::queue_status_type q_status,
   output logic                      busy,
   output logic                      push,
   output fswb_pkg::cmd_type         push_cmd
);

   logic              stage_valid_ff, stage_valid_in;
   fswb_pkg::cmd_type stage_cmd_ff, stage_cmd_in;
   fswb_pkg::cmd_type decoded;
   logic              accept;

   always_comb begin
      decoded.sec   = req_addr[fswb_pkg::ADDR_W-1:fswb_pkg::OFF_W];
      decoded.off   = req_addr[fswb_pkg::OFF_W-1:0];
      decoded.wdata = req_wdata;
      case (req_mode)
         fswb_pkg::MODE_READ:  decoded.op = fswb_pkg::OP_READ;
         fswb_pkg::MODE_WRITE: decoded.op = fswb_pkg::OP_WRITE;
         fswb_pkg::MODE_FLUSH: decoded.op = fswb_pkg::OP_FLUSH;
         default:              decoded.op = fswb_pkg::OP_NONE;
      endcase
   end

   assign busy     = hold || (stage_valid_ff && q_status.full);
   assign accept   = start && !busy;
   assign push     = stage_valid_ff && !q_status.full;
   assign push_cmd = stage_cmd_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_cmd_in   = stage_cmd_ff;
      if (push) begin
         stage_valid_in = 1'b0;
      end
      if (accept) begin
         stage_valid_in = 1'b1;
         stage_cmd_in   = decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_cmd_ff <= stage_cmd_in;
   end

endmodule

FILE: rtl/core/fswb_queue.sv
module fswb_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  fswb_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output fswb_pkg::cmd_type          head,
   output fswb_pkg::queue_status_type status
);

   fswb_pkg::cmd_type                entry_ff [fswb_pkg::QUEUE_DEPTH];
   logic [fswb_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [fswb_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [fswb_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == fswb_pkg::QCNT_W'(fswb_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + fswb_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + fswb_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + fswb_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - fswb_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/core/fswb_back.sv
module fswb_back (
   input  logic                       clock,
   input  logic                       reset,
   input  fswb_pkg::cmd_type          head,
   input  fswb_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       init_busy,
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_rdata
);

   localparam logic [2:0] S_INIT = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_WB   = 3'd3;
   localparam logic [2:0] S_LOAD = 3'd4;
   localparam logic [2:0] S_PUT  = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [fswb_pkg::SWEEP_W-1:0]   cnt_ff, cnt_in;
   logic [fswb_pkg::SWEEP_W-1:0]   cnt_dec;
   logic                           cnt_end;
   fswb_pkg::cmd_type              cur_ff, cur_in;
   logic [fswb_pkg::SEC_W-1:0]     bsec_ff, bsec_in;
   logic [fswb_pkg::SECTOR_COUNT-1:0] svalid_ff, svalid_in;
   logic                           rd_hit_ff, rd_hit_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [7:0]                     rsp_rdata_ff, rsp_rdata_in;
   logic [7:0]                     load_byte;

   logic [7:0]                     buf_mem [fswb_pkg::SECTOR_BYTES];
   logic                           buf_we;
   logic [fswb_pkg::OFF_W-1:0]     buf_wa, buf_ra;
   logic [7:0]                     buf_wd, buf_q_ff;

   logic [7:0]                     flash_mem [fswb_pkg::STORE_BYTES];
   logic                           flash_we;
   logic [fswb_pkg::ADDR_W-1:0]    flash_wa, flash_ra;
   logic [7:0]                     flash_wd, flash_q_ff;

   assign cnt_dec   = cnt_ff - fswb_pkg::SWEEP_W'(1);
   assign cnt_end   = (cnt_ff == fswb_pkg::SWEEP_W'(fswb_pkg::SECTOR_BYTES));
   assign load_byte = svalid_ff[cur_ff.sec] ? flash_q_ff : fswb_pkg::ERASED_BYTE;

   assign init_busy = (state_ff == S_INIT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_rdata = rsp_rdata_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      bsec_in      = bsec_ff;
      svalid_in    = svalid_ff;
      rd_hit_in    = rd_hit_ff;
      rsp_valid_in = 1'b0;
      rsp_rdata_in = rsp_rdata_ff;
      pop          = 1'b0;
      buf_we       = 1'b0;
      buf_wa       = cnt_dec[fswb_pkg::OFF_W-1:0];
      buf_wd       = load_byte;
      buf_ra       = cnt_ff[fswb_pkg::OFF_W-1:0];
      flash_we     = 1'b0;
      flash_wa     = {bsec_ff, cnt_dec[fswb_pkg::OFF_W-1:0]};
      flash_wd     = buf_q_ff;
      flash_ra     = {cur_ff.sec, cnt_ff[fswb_pkg::OFF_W-1:0]};
      case (state_ff)
         S_INIT: begin
            buf_we = 1'b1;
            buf_wa = cnt_ff[fswb_pkg::OFF_W-1:0];
            buf_wd = fswb_pkg::ERASED_BYTE;
            cnt_in = cnt_ff + fswb_pkg::SWEEP_W'(1);
            if (cnt_ff == fswb_pkg::SWEEP_W'(fswb_pkg::SECTOR_BYTES - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_status.empty) begin
               pop    = 1'b1;
               cur_in = head;
               case (head.op)
                  fswb_pkg::OP_READ: begin
                     buf_ra    = head.off;
                     flash_ra  = {head.sec, head.off};
                     rd_hit_in = (head.sec == bsec_ff);
                     state_in  = S_READ;
                  end
                  fswb_pkg::OP_WRITE: begin
                     if (head.sec == bsec_ff) begin
                        buf_we       = 1'b1;
                        buf_wa       = head.off;
                        buf_wd       = head.wdata;
                        rsp_valid_in = 1'b1;
                        rsp_rdata_in = head.wdata;
                     end else begin
                        cnt_in   = '0;
                        state_in = S_WB;
                     end
                  end
                  fswb_pkg::OP_FLUSH: begin
                     cnt_in   = '0;
                     state_in = S_WB;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_rdata_in = '0;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_rdata_in = rd_hit_ff ? buf_q_ff : load_byte;
            state_in     = S_IDLE;
         end
         S_WB: begin
            flash_we = (cnt_ff != '0);
            cnt_in   = cnt_ff + fswb_pkg::SWEEP_W'(1);
            if (cnt_end) begin
               svalid_in[bsec_ff] = 1'b1;
               cnt_in             = '0;
               if (cur_ff.op == fswb_pkg::OP_FLUSH) begin
                  rsp_valid_in = 1'b1;
                  rsp_rdata_in = '0;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            buf_we = (cnt_ff != '0);
            cnt_in = cnt_ff + fswb_pkg::SWEEP_W'(1);
            if (cnt_end) begin
               cnt_in   = '0;
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            buf_we       = 1'b1;
            buf_wa       = cur_ff.off;
            buf_wd       = cur_ff.wdata;
            bsec_in      = cur_ff.sec;
            rsp_valid_in = 1'b1;
            rsp_rdata_in = cur_ff.wdata;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_wa] <= buf_wd;
      end
      buf_q_ff <= buf_mem[buf_ra];
   end

   always_ff @(posedge clock) begin
      if (flash_we) begin
         flash_mem[flash_wa] <= flash_wd;
      end
      flash_q_ff <= flash_mem[flash_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         bsec_ff      <= '0;
         svalid_ff    <= '0;
         rd_hit_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         bsec_ff      <= bsec_in;
         svalid_ff    <= svalid_in;
         rd_hit_ff    <= rd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      rsp_rdata_ff <= rsp_rdata_in;
   end

endmodule

FILE: dv/fswb_checker.sv
`timescale 1ns / 100ps

module fswb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_addr,
   input  logic [7:0]  req_wdata,
   input  logic        rsp_valid,
   input  logic [7:0]  rsp_rdata,
   output int          errors,
   output int          pending
);

   logic [7:0]  flash_img  [fswb_pkg::STORE_BYTES];
   logic [7:0]  sector_img [fswb_pkg::SECTOR_BYTES];
   int unsigned held_sec;
   logic [7:0]  rdata_due [$];

   function automatic void erase_store();
      for (int i = 0; i < fswb_pkg::STORE_BYTES; i++) flash_img[i] = fswb_pkg::ERASED_BYTE;
      for (int i = 0; i < fswb_pkg::SECTOR_BYTES; i++) sector_img[i] = fswb_pkg::ERASED_BYTE;
      held_sec = 0;
   endfunction

   // write the buffer over its whole flash sector
   function automatic void store_sector();
      for (int i = 0; i < fswb_pkg::SECTOR_BYTES; i++)
         flash_img[held_sec * fswb_pkg::SECTOR_BYTES + i] = sector_img[i];
   endfunction

   function automatic logic [7:0] access_byte(input logic [1:0]  mode,
                                              input logic [15:0] addr,
                                              input logic [7:0]  wdata);
      int unsigned a;
      int unsigned sec;
      int unsigned off;
      logic [7:0]  rd;
      a   = addr % fswb_pkg::STORE_BYTES;
      sec = a / fswb_pkg::SECTOR_BYTES;
      off = a % fswb_pkg::SECTOR_BYTES;
      rd  = 8'h00;
      case (mode)
         fswb_pkg::MODE_READ: begin
            rd = (sec == held_sec) ? sector_img[off] : flash_img[a];
         end
         fswb_pkg::MODE_WRITE: begin
            if (sec != held_sec) begin
               store_sector();
               for (int i = 0; i < fswb_pkg::SECTOR_BYTES; i++)
                  sector_img[i] = flash_img[sec * fswb_pkg::SECTOR_BYTES + i];
               held_sec = sec;
            end
            sector_img[off] = wdata;
            rd = wdata;
         end
         fswb_pkg::MODE_FLUSH: begin
            store_sector();
         end
         default: ;
      endcase
      return rd;
   endfunction

   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         erase_store();
         rdata_due.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (rdata_due.size() == 0) begin
               errors++;
               $display("%0t rdata unexpected: expected none, got %02h", $time, rsp_rdata);
            end else begin
               want = rdata_due.pop_front();
               if (rsp_rdata !== want) begin
                  errors++;
                  $display("%0t rdata mismatch: expected %02h, got %02h",
                           $time, want, rsp_rdata);
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            rdata_due.push_back(access_byte(req_mode, req_addr, req_wdata));
      end
      pending = rdata_due.size();
   end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam logic [1:0] MODE_UNUSED  = 2'd3;
   localparam int         LIMIT_CYCLES = 8000000;
   localparam int         TAIL_CYCLES  = 1100;
   localparam int         PHASE_BEATS  = 420;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_mode;
   logic [15:0] req_addr;
   logic [7:0]  req_wdata;
   logic        rsp_valid;
   logic [7:0]  rsp_rdata;

   int          fail_count;
   int          due_count;
   int          cycle_count = 0;
   int          idle_pct = 0;
   int unsigned focus_sec = 0;

   flash_sector_writeback_buffer DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_mode  (req_mode),
      .req_addr  (req_addr),
      .req_wdata (req_wdata),
      .rsp_valid (rsp_valid),
      .rsp_rdata (rsp_rdata)
   );

   fswb_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_mode  (req_mode),
      .req_addr  (req_addr),
      .req_wdata (req_wdata),
      .rsp_valid (rsp_valid),
      .rsp_rdata (rsp_rdata),
      .errors    (fail_count),
      .pending   (due_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_beat(input logic [1:0]  mode,
                            input logic [15:0] addr,
                            input logic [7:0]  wdata);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start     <= 1'b1;
      req_mode  <= mode;
      req_addr  <= addr;
      req_wdata <= wdata;
      // hold start until the beat is taken
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (due_count != 0) @(negedge clock);
   endtask

   task automatic send_random(input int count);
      int unsigned sec;
      int unsigned off;
      int unsigned pick;
      logic [1:0]  mode;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 4)
            focus_sec = $urandom_range(fswb_pkg::SECTOR_COUNT - 1);
         sec  = focus_sec;
         pick = $urandom_range(99);
         if (pick < 44) begin
            mode = fswb_pkg::MODE_READ;
            if ($urandom_range(99) < 20) sec = $urandom_range(fswb_pkg::SECTOR_COUNT - 1);
         end else if (pick < 94) begin
            mode = fswb_pkg::MODE_WRITE;
         end else if (pick < 97) begin
            mode = fswb_pkg::MODE_FLUSH;
         end else begin
            mode = MODE_UNUSED;
         end
         // favour a few offsets so reads land on written bytes
         off = $urandom_range(1) ? $urandom_range(15)
                                 : $urandom_range(fswb_pkg::SECTOR_BYTES - 1);
         send_beat(mode,
                   16'(($urandom_range(15) << fswb_pkg::ADDR_W) |
                       (sec * fswb_pkg::SECTOR_BYTES + off)),
                   8'($urandom_range(255)));
      end
   endtask

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_mode  <= fswb_pkg::MODE_READ;
      req_addr  <= 16'h0000;
      req_wdata <= 8'h00;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_beat(fswb_pkg::MODE_READ,  16'h0000, 8'h00);
      send_beat(fswb_pkg::MODE_READ,  16'hFFFF, 8'h00);
      send_beat(fswb_pkg::MODE_WRITE, 16'h0000, 8'h00);
      send_beat(fswb_pkg::MODE_WRITE, 16'h01FF, 8'h5A);
      send_beat(fswb_pkg::MODE_READ,  16'h0000, 8'hFF);
      send_beat(MODE_UNUSED,          16'hFFFF, 8'hFF);
      send_beat(fswb_pkg::MODE_WRITE, 16'hFFFF, 8'hA5);
      send_beat(fswb_pkg::MODE_READ,  16'h0000, 8'h00);
      send_beat(fswb_pkg::MODE_READ,  16'h11FF, 8'h00);
      send_beat(fswb_pkg::MODE_READ,  16'h0FFF, 8'h00);
      send_beat(fswb_pkg::MODE_FLUSH, 16'h1234, 8'h77);
      send_beat(fswb_pkg::MODE_WRITE, 16'hF003, 8'hC3);
      send_beat(fswb_pkg::MODE_READ,  16'h0FFF, 8'h00);
      send_beat(fswb_pkg::MODE_READ,  16'h0003, 8'h00);
      send_beat(fswb_pkg::MODE_WRITE, 16'h0E00, 8'h3C);
      send_beat(MODE_UNUSED,          16'h0000, 8'h00);
      send_beat(fswb_pkg::MODE_READ,  16'h0E00, 8'h00);
      send_beat(fswb_pkg::MODE_READ,  16'h8003, 8'h00);
      send_beat(fswb_pkg::MODE_FLUSH, 16'h0000, 8'h00);
      send_beat(fswb_pkg::MODE_READ,  16'h0200, 8'h00);
      send_beat(fswb_pkg::MODE_WRITE, 16'h7FFF, 8'h81);
      drain();

      focus_sec = 7;
      idle_pct  = 0;
      send_random(PHASE_BEATS);
      idle_pct = 49;
      send_random(PHASE_BEATS);
      drain();
      idle_pct = 0;
      send_random(PHASE_BEATS);
      idle_pct = 24;
      send_random(PHASE_BEATS);

      @(negedge clock);
      start <= 1'b0;
      while (due_count != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && due_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
